@@ design/lzss_pkg.sv @@
// Shared constants for the LZSS decompressor: window geometry, write start
// and reference length encoding.
// No dependencies.
package lzss_pkg;

  // Window geometry
  localparam int WIN_BITS  = 12;
  localparam int WIN_DEPTH = 1 << WIN_BITS;

  // Reference encoding: length = low nibble + MIN_MATCH_OFFSET + 1
  localparam int MIN_MATCH_OFFSET = 2;
  localparam int LEN_W            = 5;
  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(MIN_MATCH_OFFSET + 1);

  // First window address written in a stream
  localparam logic [WIN_BITS-1:0] WRITE_START =
    WIN_BITS'(WIN_DEPTH - (16 + MIN_MATCH_OFFSET));

  // Fill count saturates once every window entry has been written
  localparam logic [WIN_BITS:0] FILL_FULL = (WIN_BITS + 1)'(WIN_DEPTH);

endpackage

@@ design/lzss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lzss_decompressor.sv @@
// LZSS decompressor top level: token parser, copy sequencer, output register.
// Depends on lzss_pkg and lzss_ram (4096 x 8 history window).
//
//   channel | signals                                | direction
//   --------+----------------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_byte_i,     | consumer
//           | in_last_i                              |
//   out     | out_valid_o, out_stall_i, out_byte_o,  | producer
//           | out_last_o                             |
//
// A flag byte, a literal or the first byte of a reference is taken while idle;
// a literal leaves one output beat. The second byte of a reference starts a copy
// of 3 to 18 bytes; each byte passes a window read state, then a write-back and
// emit state, as the window has a single read port and a registered read.
// Reset and each input beat marked last (a reference: when its copy ends) restore
// the empty window: a fill count masks unwritten entries, so no clearing pass.
// A stalled output holds the copy loop; new input waits until the block is idle.
module lzss_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  import lzss_pkg::*;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_REF2  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WR
  } state_e;

  state_e              st_q;
  phase_e              phase_q;
  phase_e              phase_end;
  logic [15:0]         flag_q;
  logic [15:0]         flag_sh;
  logic [7:0]          held_q;
  logic [WIN_BITS-1:0] wp_q;
  logic [WIN_BITS-1:0] wp_inc;
  logic [WIN_BITS-1:0] rp_q;
  logic [WIN_BITS-1:0] rel;
  logic [WIN_BITS:0]   fill_q;
  logic [WIN_BITS:0]   fill_inc;
  logic [LEN_W-1:0]    rem_q;
  logic                last_q;
  logic                hit_q;
  logic                rd_hit;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;

  logic                slot_free;
  logic                idle;
  logic                in_acc;
  logic                lit_acc;
  logic                wr_fire;
  logic                ram_we;
  logic                ram_re;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;
  logic [7:0]          copy_byte;

  // Handshake
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign idle       = (st_q == ST_IDLE);
  assign in_stall_o = !(idle && slot_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lit_acc    = in_acc && (phase_q == PH_TOKEN) && flag_q[0];
  assign wr_fire    = (st_q == ST_WR) && slot_free;

  // Token bookkeeping after a literal or a finished copy
  assign flag_sh   = {1'b0, flag_q[15:1]};
  assign phase_end = (flag_sh[15:8] == 8'd0) ? PH_FLAG : PH_TOKEN;

  // Shared address arithmetic
  assign wp_inc   = wp_q + 1'b1;
  assign fill_inc = (fill_q == FILL_FULL) ? fill_q : fill_q + 1'b1;
  assign rel      = rp_q - WRITE_START;
  assign rd_hit   = {1'b0, rel} < fill_q;

  // Window port control
  assign copy_byte = hit_q ? ram_rdata : 8'd0;
  assign ram_we    = lit_acc || wr_fire;
  assign ram_wdata = idle ? in_byte_i : copy_byte;
  assign ram_re    = (st_q == ST_RD);

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer, token state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_FLAG;
      flag_q      <= '0;
      held_q      <= '0;
      wp_q        <= WRITE_START;
      rp_q        <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      last_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // output slot drains when taken
      if (slot_free) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (phase_q)
              PH_TOKEN: begin
                if (flag_q[0]) begin
                  out_valid_q <= 1'b1;
                  out_byte_q  <= in_byte_i;
                  out_last_q  <= 1'b1;
                  wp_q        <= wp_inc;
                  fill_q      <= fill_inc;
                  flag_q      <= flag_sh;
                  phase_q     <= phase_end;
                end else begin
                  held_q  <= in_byte_i;
                  phase_q <= PH_REF2;
                end
              end
              PH_REF2: begin
                rp_q   <= {in_byte_i[7:4], held_q};
                rem_q  <= {1'b0, in_byte_i[3:0]} + LEN_BIAS;
                last_q <= in_last_i;
                st_q   <= ST_RD;
              end
              default: begin
                // flag byte; unused phase code is treated the same
                flag_q  <= {8'hFF, in_byte_i};
                phase_q <= PH_TOKEN;
              end
            endcase
            // end of stream, unless a copy still has to run
            if (in_last_i && (phase_q != PH_REF2)) begin
              phase_q <= PH_FLAG;
              flag_q  <= '0;
              held_q  <= '0;
              wp_q    <= WRITE_START;
              fill_q  <= '0;
            end
          end
        end
        ST_RD: begin
          hit_q <= rd_hit;
          rp_q  <= rp_q + 1'b1;
          st_q  <= ST_WR;
        end
        ST_WR: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= copy_byte;
            out_last_q  <= (rem_q == LEN_W'(1));
            wp_q        <= wp_inc;
            fill_q      <= fill_inc;
            rem_q       <= rem_q - 1'b1;
            if (rem_q == LEN_W'(1)) begin
              st_q    <= ST_IDLE;
              flag_q  <= flag_sh;
              phase_q <= phase_end;
              if (last_q) begin
                phase_q <= PH_FLAG;
                flag_q  <= '0;
                held_q  <= '0;
                wp_q    <= WRITE_START;
                fill_q  <= '0;
              end
            end else begin
              st_q <= ST_RD;
            end
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Fill count never exceeds the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill count overflow");

  // A window read is always followed by its write-back state
  a_rd_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD) |=> (st_q == ST_WR))
    else $error("copy read not followed by write-back");

  // A running copy always has bytes left
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> (rem_q != '0))
    else $error("copy running with zero length");

  // A pending reference comes from a zero flag
  a_ref_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REF2) |-> (flag_q[0] == 1'b0))
    else $error("reference phase without zero flag");

  // The final copied byte returns the block to idle with out_last set
  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_fire && (rem_q == LEN_W'(1))) |=> (idle && out_valid_q && out_last_q))
    else $error("copy end not marked");

endmodule

@@ tb/lzss_decompressor_tb.sv @@
// Testbench for lzss_decompressor: directed token and end-of-stream cases, a long
// copy-heavy stream, output back-pressure and random streams, checked against an
// in-bench decoder. Depends on lzss_pkg and the lzss_decompressor RTL.
`timescale 1ns / 1ps

module lzss_decompressor_tb;
  import lzss_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_SHOWN   = 10;

  typedef enum logic [1:0] {PH_FLAG, PH_BODY, PH_REF_HI} tok_phase_e;
  typedef enum int {END_FULL, END_CUT_FLAG, END_CUT_REF} stream_end_e;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_last;
  } out_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // Decoder state mirrored in the bench
  logic [15:0]         flags_sr;
  tok_phase_e          tok_state;
  logic [7:0]          ref_lo;
  logic [WIN_BITS-1:0] wr_addr;
  logic [7:0]          hist [WIN_DEPTH];

  out_beat_t pending_out[$];

  int items_sent  = 0;
  int n_errors    = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;

  lzss_decompressor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lzss_decompressor_tb: FAIL");
      $finish;
    end
  end

  // Empty window, write pointer back at its start
  function automatic void reset_decoder();
    flags_sr  = 16'h0000;
    tok_state = PH_FLAG;
    ref_lo    = 8'h00;
    wr_addr   = WRITE_START;
    foreach (hist[i]) hist[i] = 8'h00;
  endfunction

  // Consume one flag bit; a fresh flag byte is due once the marker byte runs out
  function automatic void next_token();
    flags_sr  = flags_sr >> 1;
    tok_state = (flags_sr[15:8] == 8'h00) ? PH_FLAG : PH_BODY;
  endfunction

  // Decode one accepted byte and queue the output beats it produces
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [WIN_BITS-1:0] rd_addr;
    logic [7:0]          v;
    int                  copy_len;
    int                  k;
    case (tok_state)
      PH_BODY: begin
        if (flags_sr[0]) begin
          hist[wr_addr] = b;
          wr_addr       = wr_addr + 1'b1;
          pending_out.push_back('{byte_val: b, is_last: 1'b1});
          next_token();
        end else begin
          ref_lo    = b;
          tok_state = PH_REF_HI;
        end
      end
      PH_REF_HI: begin
        rd_addr  = {b[7:4], ref_lo};
        copy_len = int'(b[3:0]) + MIN_MATCH_OFFSET + 1;
        // byte by byte, so an overlapping copy repeats what it just wrote
        for (k = 0; k < copy_len; k++) begin
          v             = hist[rd_addr];
          rd_addr       = rd_addr + 1'b1;
          hist[wr_addr] = v;
          wr_addr       = wr_addr + 1'b1;
          pending_out.push_back('{byte_val: v, is_last: (k == copy_len - 1)});
        end
        next_token();
      end
      default: begin
        flags_sr  = {8'hFF, b};
        tok_state = PH_BODY;
      end
    endcase
    if (last) reset_decoder();
  endfunction

  // Send one input beat after a random gap; predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, last);
    items_sent++;
  endtask

  // Build a token stream with random content and send it; dense streams are
  // mostly longest references so the window fills quickly
  task automatic send_stream(input int n_tok, input stream_end_e ending, input bit dense);
    logic [7:0]          stream_q[$];
    logic [7:0]          flags;
    logic [WIN_BITS-1:0] wr;
    logic [WIN_BITS-1:0] pos;
    logic [3:0]          len_code;
    int                  t;
    int                  k;
    wr = wr_addr;
    for (t = 0; t < n_tok; t += 8) begin
      flags = dense ? 8'($urandom & $urandom) : 8'($urandom);
      if (ending == END_CUT_REF && t + 8 >= n_tok) flags[n_tok - 1 - t] = 1'b0;
      stream_q.push_back(flags);
      for (k = 0; k < 8 && t + k < n_tok; k++) begin
        if (flags[k]) begin
          stream_q.push_back(8'($urandom));
          wr = wr + 1'b1;
        end else begin
          // mostly look back a little, sometimes anywhere in the window
          if ($urandom_range(0, 3) != 0) pos = wr - WIN_BITS'($urandom_range(1, 40));
          else pos = WIN_BITS'($urandom);
          len_code = dense ? 4'hF : 4'($urandom_range(0, 15));
          stream_q.push_back(pos[7:0]);
          if (!(ending == END_CUT_REF && t + k == n_tok - 1)) begin
            stream_q.push_back({pos[11:8], len_code});
            wr = wr + WIN_BITS'(int'(len_code) + MIN_MATCH_OFFSET + 1);
          end
        end
      end
    end
    if (ending == END_CUT_FLAG) stream_q.push_back(8'($urandom));
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Output stall: long hold-off first, else the per-beat random wait
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each output beat with the oldest expected one
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("[%0t] unexpected beat: out_byte %02h out_last %0b",
                   $time, out_byte_o, out_last_o);
      end else begin
        want = pending_out.pop_front();
        if (out_byte_o !== want.byte_val) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("[%0t] out_byte mismatch: expected %02h, got %02h",
                     $time, want.byte_val, out_byte_o);
        end
        if (out_last_o !== want.is_last) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("[%0t] out_last mismatch: expected %0b, got %0b",
                     $time, want.is_last, out_last_o);
        end
      end
      stall_left = idle_on ? $urandom_range(0, 15) : 0;
    end
  end

  // Four literals after a flag byte whose top nibble leaves four references
  task automatic test_literals();
    send_byte(8'h0F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  // Shortest copy, longest overlapping copy across the window end, copy from
  // never-written entries, copy from the wrapped start; last on the final byte
  task automatic test_references();
    send_byte(8'hEE, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h87, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // Truncated flag byte, truncated reference, window cleared, literal ending a stream
  task automatic test_stream_end();
    send_byte(8'h3C, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h21, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'hF2, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  // Long stream of mostly longest references, no idling
  task automatic test_window_fill();
    idle_on = 1'b0;
    send_stream(48, END_FULL, 1'b1);
    idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = 400;
    send_stream(32, END_FULL, 1'b0);
    idle_on   = 1'b1;
  endtask

  // Mostly complete streams, some truncated, some raw noise
  task automatic test_random_streams();
    int start_cnt;
    int pick;
    int n;
    int i;
    start_cnt = items_sent;
    while (items_sent - start_cnt < 150) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 9);
      n       = $urandom_range(1, 40);
      if (pick == 0) begin
        for (i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
      end else if (pick == 1) begin
        send_stream(8 * $urandom_range(0, 3), END_CUT_FLAG, 1'b0);
      end else if (pick == 2) begin
        send_stream(n, END_CUT_REF, 1'b0);
      end else begin
        send_stream(n, END_FULL, 1'b0);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    reset_decoder();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_literals();
    test_references();
    test_stream_end();
    test_window_fill();
    test_backpressure();
    test_random_streams();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("lzss_decompressor_tb: PASS");
    end else begin
      $display("lzss_decompressor_tb: FAIL");
    end
    $finish;
  end

endmodule
